### rtl/nge_pkg.sv
// ----------------------------------------------------------------------------
// nge_pkg
// Shared widths, register codes, reset values and divider handshake types
// for the noise gate with envelope follower.
// ----------------------------------------------------------------------------
package nge_pkg;

    localparam int unsigned SampleW = 16;
    localparam int unsigned EnvW    = 16;
    localparam int unsigned GainW   = 17;
    localparam int unsigned CountW  = 16;
    localparam int unsigned CfgIdxW = 2;
    localparam int unsigned CfgW    = 17;
    localparam int unsigned ProdW   = SampleW + GainW;

    localparam logic [CfgIdxW-1:0] CFG_OPEN_THRESHOLD = 2'd0;
    localparam logic [CfgIdxW-1:0] CFG_FLOOR_GAIN     = 2'd1;
    localparam logic [CfgIdxW-1:0] CFG_ATTACK_COUNT   = 2'd2;
    localparam logic [CfgIdxW-1:0] CFG_RELEASE_COUNT  = 2'd3;

    localparam logic [EnvW-1:0]   THRESHOLD_RESET = 16'd328;
    localparam logic [GainW-1:0]  FLOOR_RESET     = 17'd6554;
    localparam logic [CountW-1:0] ATTACK_RESET    = 16'd480;
    localparam logic [CountW-1:0] RELEASE_RESET   = 16'd4800;
    localparam logic [GainW-1:0]  UNITY_GAIN      = 17'd65536;

    typedef struct packed {
        logic              start;
        logic [GainW-1:0]  dividend;
        logic [CountW-1:0] divisor;
    } t_div_req;

    typedef struct packed {
        logic             busy;
        logic             done;
        logic [GainW-1:0] quotient;
    } t_div_rsp;

endpackage

### rtl/nge_in_if.sv
// ----------------------------------------------------------------------------
// nge_in_if
// Input channel: one audio sample word with its clip start flag.
// ----------------------------------------------------------------------------
interface nge_in_if;

    logic                                 valid;
    logic                                 ready;
    logic signed [nge_pkg::SampleW-1:0]   sample_in;
    logic                                 clip_start;

    modport source (output valid, output sample_in, output clip_start, input ready);
    modport sink   (input valid, input sample_in, input clip_start, output ready);

endinterface

### rtl/nge_out_if.sv
// ----------------------------------------------------------------------------
// nge_out_if
// Output channel: one gated sample word with its gate state.
// ----------------------------------------------------------------------------
interface nge_out_if;

    logic                                 valid;
    logic                                 ready;
    logic signed [nge_pkg::SampleW-1:0]   sample_out;
    logic                                 gate_open;

    modport source (output valid, output sample_out, output gate_open, input ready);
    modport sink   (input valid, input sample_out, input gate_open, output ready);

endinterface

### rtl/noise_gate_envelope.sv
// ----------------------------------------------------------------------------
// noise_gate_envelope
// Streaming noise gate with envelope follower on signed Q1.15 samples.
// ----------------------------------------------------------------------------
// One sample word is taken at a time. When the gate gain moves, the word
// passes through the envelope divide, the gain divide and the multiplier
// before its result is loaded into the output register. When the gain stays
// put (at or above unity with the gate open, at or below the floor with it
// closed), the gain divide is skipped. Both divides go to the shared 17-bit
// serial divider. Each pass starts it, shifts out the 17 quotient bits and
// hands back the result. It runs once for the envelope step and, when the
// gain moves, once for the gain step. A stalled output holds the word in the
// output state until the output register is free. The input is ready again as
// soon as the result is loaded, while that result waits to be taken.
// Configuration writes land in the next cycle.
module noise_gate_envelope (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [nge_pkg::CfgIdxW-1:0]   i_cfg_idx,
    input  logic [nge_pkg::CfgW-1:0]      i_cfg_data,
    nge_in_if.sink                        i_in,
    nge_out_if.source                     o_out
);

    localparam logic [2:0] S_IDLE      = 3'd0;
    localparam logic [2:0] S_ENV       = 3'd1;
    localparam logic [2:0] S_ENV_WAIT  = 3'd2;
    localparam logic [2:0] S_GAIN      = 3'd3;
    localparam logic [2:0] S_GAIN_WAIT = 3'd4;
    localparam logic [2:0] S_MUL       = 3'd5;
    localparam logic [2:0] S_OUT       = 3'd6;

    logic [2:0]                         r_state, n_state;
    logic [nge_pkg::EnvW-1:0]           r_thr;
    logic [nge_pkg::GainW-1:0]          r_floor;
    logic [nge_pkg::CountW-1:0]         r_attack;
    logic [nge_pkg::CountW-1:0]         r_release;

    logic signed [nge_pkg::SampleW-1:0] r_sample, n_sample;
    logic [nge_pkg::EnvW-1:0]           r_env, n_env;
    logic [nge_pkg::GainW-1:0]          r_gain, n_gain;
    logic                               r_up, n_up;
    logic                               r_open, n_open;
    logic signed [nge_pkg::ProdW-1:0]   r_prod, n_prod;
    logic                               r_out_valid, n_out_valid;
    logic signed [nge_pkg::SampleW-1:0] r_out_sample, n_out_sample;
    logic                               r_out_open, n_out_open;

    nge_pkg::t_div_req                  div_req;
    nge_pkg::t_div_rsp                  div_rsp;

    logic [nge_pkg::CountW-1:0]         eff_attack;
    logic [nge_pkg::CountW-1:0]         eff_release;
    logic [nge_pkg::EnvW-1:0]           mag;
    logic                               open_now;
    logic                               out_free;
    logic [nge_pkg::GainW-1:0]          q_hi;
    logic signed [nge_pkg::SampleW-1:0] sat;

    assign eff_attack  = (r_attack == '0) ? nge_pkg::CountW'(1) : r_attack;
    assign eff_release = (r_release == '0) ? nge_pkg::CountW'(1) : r_release;
    assign mag         = r_sample[nge_pkg::SampleW-1] ? (~r_sample + nge_pkg::SampleW'(1))
                                                      : r_sample;
    assign open_now    = r_env > r_thr;
    assign out_free    = !r_out_valid || o_out.ready;

    assign q_hi = r_prod[nge_pkg::ProdW-1:nge_pkg::SampleW];
    always_comb begin
        if (r_prod[nge_pkg::ProdW-1] == r_prod[nge_pkg::ProdW-2]) begin
            sat = r_prod[nge_pkg::ProdW-2:nge_pkg::SampleW];
        end else if (r_prod[nge_pkg::ProdW-1]) begin
            sat = {1'b1, {(nge_pkg::SampleW-1){1'b0}}};
        end else begin
            sat = {1'b0, {(nge_pkg::SampleW-1){1'b1}}};
        end
    end

    nge_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (div_req),
        .o_rsp   (div_rsp)
    );

    always_comb begin
        n_state      = r_state;
        n_sample     = r_sample;
        n_env        = r_env;
        n_gain       = r_gain;
        n_up         = r_up;
        n_open       = r_open;
        n_prod       = r_prod;
        n_out_valid  = r_out_valid;
        n_out_sample = r_out_sample;
        n_out_open   = r_out_open;
        div_req      = '0;

        if (r_out_valid && o_out.ready) begin
            n_out_valid = 1'b0;
        end

        unique case (r_state)
            S_IDLE: begin
                if (i_in.valid) begin
                    n_sample = i_in.sample_in;
                    if (i_in.clip_start) begin
                        n_env  = '0;
                        n_gain = r_floor;
                    end
                    n_state = S_ENV;
                end
            end
            S_ENV: begin
                n_up          = mag > r_env;
                div_req.start = 1'b1;
                if (mag > r_env) begin
                    div_req.dividend = nge_pkg::GainW'(mag - r_env);
                    div_req.divisor  = eff_attack;
                end else begin
                    div_req.dividend = nge_pkg::GainW'(r_env - mag);
                    div_req.divisor  = eff_release;
                end
                n_state = S_ENV_WAIT;
            end
            S_ENV_WAIT: begin
                if (div_rsp.done) begin
                    n_env = r_up ? r_env + div_rsp.quotient[nge_pkg::EnvW-1:0]
                                 : r_env - div_rsp.quotient[nge_pkg::EnvW-1:0];
                    n_state = S_GAIN;
                end
            end
            S_GAIN: begin
                n_open = open_now;
                n_up   = open_now;
                priority if (open_now && r_gain < nge_pkg::UNITY_GAIN) begin
                    div_req.start    = 1'b1;
                    div_req.dividend = nge_pkg::UNITY_GAIN - r_gain;
                    div_req.divisor  = eff_attack;
                    n_state          = S_GAIN_WAIT;
                end else if (!open_now && r_gain > r_floor) begin
                    div_req.start    = 1'b1;
                    div_req.dividend = r_gain - r_floor;
                    div_req.divisor  = eff_release;
                    n_state          = S_GAIN_WAIT;
                end else begin
                    n_state = S_MUL;
                end
            end
            S_GAIN_WAIT: begin
                if (div_rsp.done) begin
                    n_gain  = r_up ? r_gain + div_rsp.quotient : r_gain - div_rsp.quotient;
                    n_state = S_MUL;
                end
            end
            S_MUL: begin
                n_prod  = nge_pkg::ProdW'(r_sample)
                        * nge_pkg::ProdW'($signed({1'b0, r_gain}));
                n_state = S_OUT;
            end
            S_OUT: begin
                if (out_free) begin
                    n_out_valid  = 1'b1;
                    n_out_sample = sat;
                    n_out_open   = r_open;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
            r_thr       <= nge_pkg::THRESHOLD_RESET;
            r_floor     <= nge_pkg::FLOOR_RESET;
            r_attack    <= nge_pkg::ATTACK_RESET;
            r_release   <= nge_pkg::RELEASE_RESET;
            r_env       <= '0;
            r_gain      <= nge_pkg::FLOOR_RESET;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
            r_env       <= n_env;
            r_gain      <= n_gain;
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    nge_pkg::CFG_OPEN_THRESHOLD: r_thr     <= i_cfg_data[nge_pkg::EnvW-1:0];
                    nge_pkg::CFG_FLOOR_GAIN:     r_floor   <= i_cfg_data[nge_pkg::GainW-1:0];
                    nge_pkg::CFG_ATTACK_COUNT:   r_attack  <= i_cfg_data[nge_pkg::CountW-1:0];
                    nge_pkg::CFG_RELEASE_COUNT:  r_release <= i_cfg_data[nge_pkg::CountW-1:0];
                    default: ;
                endcase
            end
        end
        r_sample     <= n_sample;
        r_up         <= n_up;
        r_open       <= n_open;
        r_prod       <= n_prod;
        r_out_sample <= n_out_sample;
        r_out_open   <= n_out_open;
    end

    assign i_in.ready       = (r_state == S_IDLE);
    assign o_out.valid      = r_out_valid;
    assign o_out.sample_out = r_out_sample;
    assign o_out.gate_open  = r_out_open;

`ifndef SYNTHESIS
    a_ready_div_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in.ready |-> !div_rsp.busy)
        else $error("input ready while divider busy");

    a_done_in_wait: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_rsp.done |-> (r_state == S_ENV_WAIT || r_state == S_GAIN_WAIT))
        else $error("divider result outside a wait state");

    a_out_loaded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_OUT && out_free) |=> (o_out.valid && i_in.ready))
        else $error("result word not loaded");

    a_prod_width: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_OUT && q_hi[nge_pkg::GainW-1] == q_hi[nge_pkg::GainW-2])
            |-> (sat == $signed(q_hi[nge_pkg::SampleW-1:0])))
        else $error("unsaturated product mismatch");
`endif

endmodule

### rtl/nge_div.sv
// ----------------------------------------------------------------------------
// nge_div
// Restoring serial divider, one quotient bit per cycle. Divides a 17-bit
// dividend by a nonzero 16-bit divisor, truncating.
// ----------------------------------------------------------------------------
module nge_div (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  nge_pkg::t_div_req i_req,
    output nge_pkg::t_div_rsp o_rsp
);

    localparam int unsigned CntW = $clog2(nge_pkg::GainW + 1);

    logic [nge_pkg::CountW-1:0] r_rem, n_rem;
    logic [nge_pkg::GainW-1:0]  r_quo, n_quo;
    logic [nge_pkg::CountW-1:0] r_div, n_div;
    logic [CntW-1:0]            r_cnt, n_cnt;
    logic                       r_busy, n_busy;
    logic                       r_done, n_done;

    logic [nge_pkg::GainW-1:0]  rem_sh;
    logic [nge_pkg::GainW-1:0]  rem_sub;
    logic                       ge;

    assign rem_sh  = {r_rem, r_quo[nge_pkg::GainW-1]};
    assign ge      = rem_sh >= {1'b0, r_div};
    assign rem_sub = rem_sh - {1'b0, r_div};

    always_comb begin
        n_rem  = r_rem;
        n_quo  = r_quo;
        n_div  = r_div;
        n_cnt  = r_cnt;
        n_busy = r_busy;
        n_done = 1'b0;
        if (i_req.start) begin
            n_rem  = '0;
            n_quo  = i_req.dividend;
            n_div  = i_req.divisor;
            n_cnt  = CntW'(nge_pkg::GainW);
            n_busy = 1'b1;
        end else if (r_busy) begin
            n_rem = ge ? rem_sub[nge_pkg::CountW-1:0] : rem_sh[nge_pkg::CountW-1:0];
            n_quo = {r_quo[nge_pkg::GainW-2:0], ge};
            n_cnt = r_cnt - CntW'(1);
            if (r_cnt == CntW'(1)) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt  <= '0;
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_cnt  <= n_cnt;
            r_busy <= n_busy;
            r_done <= n_done;
        end
        r_rem <= n_rem;
        r_quo <= n_quo;
        r_div <= n_div;
    end

    assign o_rsp.busy     = r_busy;
    assign o_rsp.done     = r_done;
    assign o_rsp.quotient = r_quo;

endmodule
